// ----- rtl/spg_pkg.sv -----
`timescale 1ns / 1ps

package spg_pkg;

  // Configuration register indexes
  localparam int unsigned NumSteps = 6;
  localparam logic [2:0] REG_RED_A_STEP   = 3'd0;
  localparam logic [2:0] REG_RED_B_STEP   = 3'd1;
  localparam logic [2:0] REG_GREEN_A_STEP = 3'd2;
  localparam logic [2:0] REG_GREEN_B_STEP = 3'd3;
  localparam logic [2:0] REG_BLUE_A_STEP  = 3'd4;
  localparam logic [2:0] REG_BLUE_B_STEP  = 3'd5;

  localparam logic [7:0] RED_A_STEP_RST   = 8'd6;
  localparam logic [7:0] RED_B_STEP_RST   = 8'd5;
  localparam logic [7:0] GREEN_A_STEP_RST = 8'd4;
  localparam logic [7:0] GREEN_B_STEP_RST = 8'd6;
  localparam logic [7:0] BLUE_A_STEP_RST  = 8'd5;
  localparam logic [7:0] BLUE_B_STEP_RST  = 8'd4;

  typedef struct packed {
    logic [4:0] column;
    logic [2:0] row;
    logic       end_of_frame;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] pixel_index;
    logic [3:0] red_level;
    logic [3:0] green_level;
    logic [3:0] blue_level;
    logic       frame_done;
  } pixel_out_t;

  // One classified pixel waiting for its lookups
  typedef struct packed {
    logic [7:0] pixel_index;
    logic [7:0] red_a_addr;
    logic [7:0] red_b_addr;
    logic [7:0] green_a_addr;
    logic [7:0] green_b_addr;
    logic [7:0] blue_a_addr;
    logic [7:0] blue_b_addr;
    logic       frame_done;
  } job_t;

  localparam logic [7:0] SINE_ROM [256] = '{
    8'h80,8'h83,8'h86,8'h89,8'h8C,8'h8F,8'h92,8'h95,8'h98,8'h9B,8'h9E,8'hA2,8'hA5,8'hA7,8'hAA,8'hAD,
    8'hB0,8'hB3,8'hB6,8'hB9,8'hBC,8'hBE,8'hC1,8'hC4,8'hC6,8'hC9,8'hCB,8'hCE,8'hD0,8'hD3,8'hD5,8'hD7,
    8'hDA,8'hDC,8'hDE,8'hE0,8'hE2,8'hE4,8'hE6,8'hE8,8'hEA,8'hEB,8'hED,8'hEE,8'hF0,8'hF1,8'hF3,8'hF4,
    8'hF5,8'hF6,8'hF8,8'hF9,8'hFA,8'hFA,8'hFB,8'hFC,8'hFD,8'hFD,8'hFE,8'hFE,8'hFE,8'hFF,8'hFF,8'hFF,
    8'hFF,8'hFF,8'hFF,8'hFF,8'hFE,8'hFE,8'hFE,8'hFD,8'hFD,8'hFC,8'hFB,8'hFA,8'hFA,8'hF9,8'hF8,8'hF6,
    8'hF5,8'hF4,8'hF3,8'hF1,8'hF0,8'hEE,8'hED,8'hEB,8'hEA,8'hE8,8'hE6,8'hE4,8'hE2,8'hE0,8'hDE,8'hDC,
    8'hDA,8'hD7,8'hD5,8'hD3,8'hD0,8'hCE,8'hCB,8'hC9,8'hC6,8'hC4,8'hC1,8'hBE,8'hBC,8'hB9,8'hB6,8'hB3,
    8'hB0,8'hAD,8'hAA,8'hA7,8'hA5,8'hA2,8'h9E,8'h9B,8'h98,8'h95,8'h92,8'h8F,8'h8C,8'h89,8'h86,8'h83,
    8'h80,8'h7C,8'h79,8'h76,8'h73,8'h70,8'h6D,8'h6A,8'h67,8'h64,8'h61,8'h5D,8'h5A,8'h58,8'h55,8'h52,
    8'h4F,8'h4C,8'h49,8'h46,8'h43,8'h41,8'h3E,8'h3B,8'h39,8'h36,8'h34,8'h31,8'h2F,8'h2C,8'h2A,8'h28,
    8'h25,8'h23,8'h21,8'h1F,8'h1D,8'h1B,8'h19,8'h17,8'h15,8'h14,8'h12,8'h11,8'h0F,8'h0E,8'h0C,8'h0B,
    8'h0A,8'h09,8'h07,8'h06,8'h05,8'h05,8'h04,8'h03,8'h02,8'h02,8'h01,8'h01,8'h01,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h01,8'h01,8'h01,8'h02,8'h02,8'h03,8'h04,8'h05,8'h05,8'h06,8'h07,8'h09,
    8'h0A,8'h0B,8'h0C,8'h0E,8'h0F,8'h11,8'h12,8'h14,8'h15,8'h17,8'h19,8'h1B,8'h1D,8'h1F,8'h21,8'h23,
    8'h25,8'h28,8'h2A,8'h2C,8'h2F,8'h31,8'h34,8'h36,8'h39,8'h3B,8'h3E,8'h41,8'h43,8'h46,8'h49,8'h4C,
    8'h4F,8'h52,8'h55,8'h58,8'h5A,8'h5D,8'h61,8'h64,8'h67,8'h6A,8'h6D,8'h70,8'h73,8'h76,8'h79,8'h7C
  };

  // Scale two sine samples to 0..31 each and divide their sum by four, giving 0..15
  function automatic logic [3:0] blend(input logic [7:0] addr_a, input logic [7:0] addr_b);
    logic [5:0] sum;
    sum = {1'b0, SINE_ROM[addr_a][7:3]} + {1'b0, SINE_ROM[addr_b][7:3]};
    return sum[5:2];
  endfunction

endpackage

// ----- rtl/sine_plasma_pixel_generator.sv -----
`timescale 1ns / 1ps

// Sine plasma pixel generator for a serpentine-wired LED matrix. Each input
// word names one pixel (column, row, end_of_frame); each output word carries
// its strip index (odd columns run bottom to top) and 4-bit red, green and
// blue levels, each a quarter of the sum of two sine samples scaled to 0..31.
// The table addresses add per-colour phase counters to terms built from the
// coordinates; a word with end_of_frame set is rendered with the current
// phases, after which all six phases advance by their step registers, modulo
// 256. One pixel is accepted per clock while in_stall is low. Each accepted
// word is classified into a two-entry queue; the head entry is looked up and
// loaded into the output register when that register is free or being taken,
// and is held there while the output is stalled. The queue decouples the two
// halves: input stall rises only when both queue entries are held behind a
// stalled output.
// Step registers: index 0..5 = red A, red B, green A, green B, blue A, blue B
// (reset 6, 5, 4, 6, 5, 4); writes to other indexes are dropped. Write them
// only while the block is idle.

module sine_plasma_pixel_generator #(
  parameter int MATRIX_COLUMNS = 32,
  parameter int MATRIX_ROWS    = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  spg_pkg::pixel_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output spg_pkg::pixel_out_t out_data,
  input  logic                cfg_en,
  input  logic [2:0]          cfg_index,
  input  logic [7:0]          cfg_data
);
  import spg_pkg::*;

  job_t push_job, head_job;
  logic push, pop, full, empty;

  // Front: accept, work out index and addresses, advance phases
  spg_front #(
    .MATRIX_COLUMNS(MATRIX_COLUMNS),
    .MATRIX_ROWS   (MATRIX_ROWS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg_en   (cfg_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_full   (full),
    .q_push   (push),
    .q_job    (push_job)
  );

  // Hold classified pixels between the two halves
  spg_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .full    (full),
    .pop     (pop),
    .empty   (empty),
    .head_job(head_job)
  );

  // Back: sine lookups, blend, output register
  spg_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (empty),
    .q_job    (head_job),
    .q_pop    (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

// ----- rtl/spg_front.sv -----
`timescale 1ns / 1ps

module spg_front #(
  parameter int MATRIX_COLUMNS = 32,
  parameter int MATRIX_ROWS    = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  spg_pkg::pixel_in_t in_data,
  input  logic               cfg_en,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               q_full,
  output logic               q_push,
  output spg_pkg::job_t      q_job
);
  import spg_pkg::*;

  localparam logic [7:0] Cols8 = 8'(MATRIX_COLUMNS);
  localparam logic [7:0] Rows8 = 8'(MATRIX_ROWS);

  logic [7:0] steps [NumSteps];
  logic [7:0] red_phase_a, red_phase_b;
  logic [7:0] green_phase_a, green_phase_b;
  logic [7:0] blue_phase_a, blue_phase_b;

  logic [7:0] col8, row8, base_index;
  logic       accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  assign col8       = {3'b000, in_data.column};
  assign row8       = {5'b00000, in_data.row};
  assign base_index = 8'(col8 * Rows8);

  // Work out the strip index and all six table addresses from the current phases
  always_comb begin
    q_job.pixel_index  = in_data.column[0] ? 8'(base_index + Rows8 - 8'd1 - row8)
                                           : 8'(base_index + row8);
    q_job.red_a_addr   = 8'((row8 << 2) + red_phase_a);
    q_job.red_b_addr   = 8'((col8 << 1) + red_phase_b);
    q_job.green_a_addr = 8'((row8 << 2) + green_phase_a);
    q_job.green_b_addr = 8'(((Cols8 - col8) << 2) + green_phase_b);
    q_job.blue_a_addr  = 8'(((Rows8 - row8) << 1) + blue_phase_a);
    q_job.blue_b_addr  = 8'((col8 << 2) + blue_phase_b);
    q_job.frame_done   = in_data.end_of_frame;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps[0] <= RED_A_STEP_RST;
      steps[1] <= RED_B_STEP_RST;
      steps[2] <= GREEN_A_STEP_RST;
      steps[3] <= GREEN_B_STEP_RST;
      steps[4] <= BLUE_A_STEP_RST;
      steps[5] <= BLUE_B_STEP_RST;
    end else if (cfg_en) begin
      unique case (cfg_index)
        REG_RED_A_STEP:   steps[0] <= cfg_data;
        REG_RED_B_STEP:   steps[1] <= cfg_data;
        REG_GREEN_A_STEP: steps[2] <= cfg_data;
        REG_GREEN_B_STEP: steps[3] <= cfg_data;
        REG_BLUE_A_STEP:  steps[4] <= cfg_data;
        REG_BLUE_B_STEP:  steps[5] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the phases once the last pixel of a frame has been classified
  always_ff @(posedge clk) begin
    if (rst) begin
      red_phase_a   <= '0;
      red_phase_b   <= '0;
      green_phase_a <= '0;
      green_phase_b <= '0;
      blue_phase_a  <= '0;
      blue_phase_b  <= '0;
    end else if (accept && in_data.end_of_frame) begin
      red_phase_a   <= red_phase_a + steps[0];
      red_phase_b   <= red_phase_b + steps[1];
      green_phase_a <= green_phase_a + steps[2];
      green_phase_b <= green_phase_b + steps[3];
      blue_phase_a  <= blue_phase_a + steps[4];
      blue_phase_b  <= blue_phase_b + steps[5];
    end
  end

endmodule

// ----- rtl/spg_queue.sv -----
`timescale 1ns / 1ps

module spg_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  spg_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output spg_pkg::job_t head_job
);
  import spg_pkg::*;

  job_t       slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign head_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/spg_back.sv -----
`timescale 1ns / 1ps

module spg_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  spg_pkg::job_t       q_job,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output spg_pkg::pixel_out_t out_data
);
  import spg_pkg::*;

  // Load the output register whenever the queue holds a job and the register is free or being taken
  assign q_pop = !q_empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data.pixel_index <= q_job.pixel_index;
      out_data.red_level   <= blend(q_job.red_a_addr, q_job.red_b_addr);
      out_data.green_level <= blend(q_job.green_a_addr, q_job.green_b_addr);
      out_data.blue_level  <= blend(q_job.blue_a_addr, q_job.blue_b_addr);
      out_data.frame_done  <= q_job.frame_done;
    end
  end

endmodule
